[rtl/sli_pkg.sv]
// Shared types and codes for the sorted list insert unit.
// No dependencies; used by sli_ctrl, sli_datapath and sorted_list_insert_unit.
package sli_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned STAT_W = 2;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [1:0] {
        DP_NOP,
        DP_APPEND,
        DP_INSERT,
        DP_ROTATE
    } t_dp_op;

    typedef struct packed {
        t_dp_op                   op;
        logic signed [DATA_W-1:0] value;
    } t_dp_cmd;

    typedef struct packed {
        logic                     full;
        logic                     empty;
        logic signed [DATA_W-1:0] head;
    } t_dp_stat;

endpackage

[rtl/sorted_list_insert_unit.sv]
// Sorted list insert unit: append, sorted insert and display over a bank of DEPTH cells.
// Append/insert: 1 request per cycle if results drain, result the cycle after accept; full list
// -> dropped, flagged. Display of N entries: request held to the end; display state, then head
// loaded as first entry, then one per cycle if results drain (cell row rotates once per entry,
// N rotations restore it). Empty display: one status result. Unused code: swallowed, no result.
// Reset (i_rst_n low, synchronous): list empty, no result pending; cell contents are not cleared.
module sorted_list_insert_unit #(
    parameter int unsigned DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // [31:0] value
    input  logic [1:0]  i_s_tuser,     // [1:0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,     // [31:0] entry_value
    output logic [1:0]  o_m_tuser,     // [1:0] status
    output logic        o_m_tlast      // last result of this request
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    sli_pkg::t_dp_cmd                  w_dp_cmd;
    sli_pkg::t_dp_stat                 w_dp_stat;
    logic [CW-1:0]                     w_count;
    logic signed [sli_pkg::DATA_W-1:0] w_entry;

    // Controller: handshakes, display sequencing, result register.
    sli_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_command     (i_s_tuser),
        .i_value       ($signed(i_s_tdata)),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_entry_value (w_entry),
        .o_status      (o_m_tuser),
        .o_last        (o_m_tlast),
        .o_dp_cmd      (w_dp_cmd),
        .i_dp_stat     (w_dp_stat),
        .i_count       (w_count)
    );

    // Datapath: cells compare against the request value in parallel and shift together.
    sli_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_dp_cmd),
        .o_stat  (w_dp_stat),
        .o_count (w_count)
    );

    assign o_m_tdata = $unsigned(w_entry);

endmodule

[rtl/sli_datapath.sv]
// Cell bank of the sorted list: parallel compare, shift-insert, append and rotate.
// Depends on sli_pkg.
module sli_datapath #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sli_pkg::t_dp_cmd             i_cmd,
    output sli_pkg::t_dp_stat            o_stat,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [sli_pkg::DATA_W-1:0] r_cell [DEPTH];
    logic signed [sli_pkg::DATA_W-1:0] n_cell [DEPTH];
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;

    logic [DEPTH-1:0] w_gt;     // valid cell strictly greater than request value
    logic [DEPTH-1:0] w_pre;    // some greater cell sits nearer the head
    logic             w_any_gt;
    logic             w_full;

    assign w_full = (r_count == CW'(DEPTH));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CW'(i) < r_count) && (r_cell[i] > i_cmd.value);
        end
        for (int i = 0; i < DEPTH; i++) begin
            w_pre[i] = |(w_gt & ((DEPTH'(1) << i) - DEPTH'(1)));
        end
        w_any_gt = |w_gt;
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        unique case (i_cmd.op)
            sli_pkg::DP_APPEND: begin
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CW'(i) == r_count) n_cell[i] = i_cmd.value;
                    end
                end
            end
            sli_pkg::DP_INSERT: begin
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_pre[i] && CW'(i) <= r_count) begin
                            n_cell[i] = r_cell[(i == 0) ? 0 : i - 1];
                        end else if ((w_gt[i] && !w_pre[i]) ||
                                     (!w_any_gt && CW'(i) == r_count)) begin
                            n_cell[i] = i_cmd.value;
                        end
                    end
                end
            end
            sli_pkg::DP_ROTATE: begin
                // circular shift toward the head within the valid entries
                for (int i = 0; i < DEPTH; i++) begin
                    if (CW'(i + 1) < r_count) begin
                        n_cell[i] = r_cell[(i == DEPTH - 1) ? i : i + 1];
                    end else if (CW'(i + 1) == r_count) begin
                        n_cell[i] = r_cell[0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    assign o_stat.full  = w_full;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_cell[0];
    assign o_count      = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_rotate_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == sli_pkg::DP_ROTATE || i_cmd.op == sli_pkg::DP_NOP) |=> $stable(r_count))
        else $error("count moved without a write");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && (i_cmd.op == sli_pkg::DP_APPEND || i_cmd.op == sli_pkg::DP_INSERT))
        |=> $stable(r_count))
        else $error("write taken on a full list");

endmodule

[rtl/sli_ctrl.sv]
// Request controller: decodes commands, sequences display runs, owns the result register.
// Depends on sli_pkg; drives sli_datapath.
module sli_ctrl #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sli_pkg::CMD_W-1:0]         i_command,
    input  logic signed [sli_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [sli_pkg::DATA_W-1:0] o_entry_value,
    output logic [sli_pkg::STAT_W-1:0]        o_status,
    output logic                              o_last,
    output sli_pkg::t_dp_cmd                  o_dp_cmd,
    input  sli_pkg::t_dp_stat                 i_dp_stat,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_DISP
    } t_state;

    t_state                            r_state;
    logic [CW-1:0]                     r_idx;
    logic                              r_valid;
    logic signed [sli_pkg::DATA_W-1:0] r_data;
    logic [sli_pkg::STAT_W-1:0]        r_status;
    logic                              r_last;

    logic w_slot;       // result register free this cycle
    logic w_acc;
    logic w_emit;
    logic w_disp_last;
    logic w_load;       // result register loaded this cycle

    assign w_slot      = !r_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_emit      = (r_state == S_DISP) && w_slot;
    assign w_disp_last = (r_idx == i_count - CW'(1));
    assign w_load      = (w_acc && (i_command == sli_pkg::CMD_APPEND ||
                                    i_command == sli_pkg::CMD_INSERT ||
                                    (i_command == sli_pkg::CMD_DISPLAY && i_dp_stat.empty)))
                         || w_emit;

    always_comb begin
        o_dp_cmd.op    = sli_pkg::DP_NOP;
        o_dp_cmd.value = i_value;
        if (w_acc && i_command == sli_pkg::CMD_APPEND) begin
            o_dp_cmd.op = sli_pkg::DP_APPEND;
        end else if (w_acc && i_command == sli_pkg::CMD_INSERT) begin
            o_dp_cmd.op = sli_pkg::DP_INSERT;
        end else if (w_emit) begin
            o_dp_cmd.op = sli_pkg::DP_ROTATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (w_slot) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        priority if (i_command == sli_pkg::CMD_APPEND ||
                                     i_command == sli_pkg::CMD_INSERT) begin
                            r_data   <= '0;
                            r_status <= i_dp_stat.full ? sli_pkg::ST_FULL : sli_pkg::ST_OK;
                            r_last   <= 1'b1;
                        end else if (i_command == sli_pkg::CMD_DISPLAY) begin
                            if (i_dp_stat.empty) begin
                                r_data   <= '0;
                                r_status <= sli_pkg::ST_EMPTY;
                                r_last   <= 1'b1;
                            end else begin
                                r_state <= S_DISP;
                                r_idx   <= '0;
                            end
                        end else begin
                            // unused code: swallowed, no result
                        end
                    end
                end
                S_DISP: begin
                    if (w_emit) begin
                        r_data   <= i_dp_stat.head;
                        r_status <= sli_pkg::ST_OK;
                        r_last   <= w_disp_last;
                        r_idx    <= r_idx + CW'(1);
                        if (w_disp_last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_valid;
    assign o_entry_value = r_data;
    assign o_status      = r_status;
    assign o_last        = r_last;

    a_disp_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (r_idx < i_count))
        else $error("display index past the tail");

    a_disp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_disp_last) |=> (r_state == S_IDLE && r_valid && r_last))
        else $error("display run did not close with last");

    a_no_write_in_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP) |-> (o_dp_cmd.op != sli_pkg::DP_APPEND &&
                                 o_dp_cmd.op != sli_pkg::DP_INSERT))
        else $error("list written during display");

endmodule
